// ===== design/assert_macros.svh =====
// Assertion macros shared by the compensation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ptc_pkg.sv =====
// Types, constants and helpers of the pressure and temperature compensation block.
`default_nettype none
package ptc_pkg;

  localparam logic [2:0] REG_T1   = 3'd0;
  localparam logic [2:0] REG_T2   = 3'd1;
  localparam logic [2:0] REG_T3   = 3'd2;
  localparam logic [2:0] REG_P1   = 3'd3;
  localparam logic [2:0] REG_P2_5 = 3'd4;
  localparam logic [2:0] REG_P6_9 = 3'd5;

  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_BASE  = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [63:0] P1_BIAS     = 64'h0000_8000_0000_0000;

  // Everything one item carries down the pipeline; unused fields are pruned.
  typedef struct packed {
    logic             vld;
    logic [19:0]      at;
    logic [19:0]      ap;
    logic [31:0]      tf;
    logic [31:0]      tc;
    logic             dz;
    logic             qneg;
    logic [63:0]      w0;
    logic [63:0]      w1;
    logic [63:0]      w2;
    logic [3:0][63:0] ma;
    logic [3:0][63:0] mb;
    logic [31:0]      rem;
    logic [31:0]      den;
    logic [63:0]      num;
    logic [31:0]      pout;
  } ptc_ctx_t;

  function automatic logic [63:0] ptc_asr(input logic [63:0] x, input int unsigned n);
    logic signed [63:0] xs;
    xs = x;
    return xs >>> n;
  endfunction

  function automatic logic [63:0] ptc_sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== design/ptc_mul64.sv =====
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product.
`default_nettype none
module ptc_mul64 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] p
);

  logic [63:0] ll_r, ll_nxt;
  logic [31:0] hl_r, hl_nxt;
  logic [31:0] lh_r, lh_nxt;
  logic [63:0] p_r, p_nxt;

  // Only the cross terms' low halves reach the low 64 bits of the product.
  always_comb begin
    ll_nxt = a[31:0] * b[31:0];
    hl_nxt = a[63:32] * b[31:0];
    lh_nxt = a[31:0] * b[63:32];
    p_nxt  = ll_r + {hl_r + lh_r, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_nxt;
      hl_r <= hl_nxt;
      lh_r <= lh_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== design/pressure_temperature_compensation.sv =====
// Top level of the barometric pressure and temperature compensation pipeline.
//
// Channel | Direction | Handshake           | Contents
// in_     | input     | in_tvalid/tready    | raw temperature and raw pressure
// out_    | output    | out_tvalid/tready   | fine temp, centi temp, pressure; flag
// cfg_    | input     | cfg_wr_en           | calibration words T1..T3, P1..P9
//
// One word is accepted every cycle while the output buffer is not full; each passes
// through 61 pipeline registers (fourteen two-stage multipliers and a 32-stage
// radix-4 divider for the pressure quotient) and then the output register.
// Reset clears all valid bits and calibration registers.
// A two-entry output buffer lets the pipeline keep taking words while a result
// waits; the whole pipeline freezes only once that buffer is full.
`default_nettype none
`include "assert_macros.svh"
module pressure_temperature_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [95:0] out_tdata,  // fine_temperature[31:0], temperature_centi[63:32],
                                       // pressure_q24_8[95:64]
  output logic             out_tuser,  // divide_by_zero
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  localparam int NST        = 61;
  localparam int ST_T2      = 3;
  localparam int ST_TF      = 6;
  localparam int ST_X       = 7;
  localparam int ST_TC      = 10;
  localparam int ST_SUM     = 13;
  localparam int ST_DIVOP   = 14;
  localparam int ST_QUOT    = 17;
  localparam int ST_DIV     = 18;
  localparam int DIV_STAGES = 32;
  localparam int ST_NEG     = ST_DIV + DIV_STAGES + 1;
  localparam int ST_PS      = ST_NEG + 1;
  localparam int ST_SQ      = ST_PS + 3;
  localparam int ST_ADD1    = ST_SQ + 3;
  localparam int ST_ADD2    = ST_ADD1 + 1;
  localparam int ST_CLAMP   = ST_ADD2 + 1;

  logic [15:0] t1_r, t2_r, t3_r, p1_r;
  logic [63:0] p25_r, p69_r;

  ptc_pkg::ptc_ctx_t st_r   [NST];
  ptc_pkg::ptc_ctx_t st_nxt [NST];

  logic        pipe_en;
  logic [63:0] p1a, p1b, p2, q0, q1, q2, q3, r0, r1, e0, e1, f0, f1, g0;

  logic        out_tvalid_r;
  logic [95:0] out_tdata_r;
  logic        out_tuser_r;
  logic        skid_full_r;
  logic [95:0] skid_data_r;
  logic        skid_user_r;
  logic [95:0] last_data;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t2_r  <= '0;
      t3_r  <= '0;
      p1_r  <= '0;
      p25_r <= '0;
      p69_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ptc_pkg::REG_T1:   t1_r  <= cfg_wdata[15:0];
        ptc_pkg::REG_T2:   t2_r  <= cfg_wdata[15:0];
        ptc_pkg::REG_T3:   t3_r  <= cfg_wdata[15:0];
        ptc_pkg::REG_P1:   p1_r  <= cfg_wdata[15:0];
        ptc_pkg::REG_P2_5: p25_r <= cfg_wdata;
        ptc_pkg::REG_P6_9: p69_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pipe_en   = !skid_full_r;
  assign in_tready = pipe_en;

  // Multipliers; each product lines up with the stage two after its operands.
  ptc_mul64 u_mul_a1 (.clk, .en(pipe_en), .a(st_r[0].ma[0]), .b(st_r[0].mb[0]), .p(p1a));
  ptc_mul64 u_mul_a2 (.clk, .en(pipe_en), .a(st_r[0].ma[1]), .b(st_r[0].mb[1]), .p(p1b));
  ptc_mul64 u_mul_b  (.clk, .en(pipe_en), .a(st_r[ST_T2].ma[0]), .b(st_r[ST_T2].mb[0]),
                      .p(p2));
  ptc_mul64 u_mul_c0 (.clk, .en(pipe_en), .a(st_r[ST_X].ma[0]), .b(st_r[ST_X].mb[0]), .p(q0));
  ptc_mul64 u_mul_c1 (.clk, .en(pipe_en), .a(st_r[ST_X].ma[1]), .b(st_r[ST_X].mb[1]), .p(q1));
  ptc_mul64 u_mul_c2 (.clk, .en(pipe_en), .a(st_r[ST_X].ma[2]), .b(st_r[ST_X].mb[2]), .p(q2));
  ptc_mul64 u_mul_c3 (.clk, .en(pipe_en), .a(st_r[ST_X].ma[3]), .b(st_r[ST_X].mb[3]), .p(q3));
  ptc_mul64 u_mul_d0 (.clk, .en(pipe_en), .a(st_r[ST_TC].ma[0]), .b(st_r[ST_TC].mb[0]),
                      .p(r0));
  ptc_mul64 u_mul_d1 (.clk, .en(pipe_en), .a(st_r[ST_TC].ma[1]), .b(st_r[ST_TC].mb[1]),
                      .p(r1));
  ptc_mul64 u_mul_e0 (.clk, .en(pipe_en), .a(st_r[ST_DIVOP].ma[0]),
                      .b(st_r[ST_DIVOP].mb[0]), .p(e0));
  ptc_mul64 u_mul_e1 (.clk, .en(pipe_en), .a(st_r[ST_DIVOP].ma[1]),
                      .b(st_r[ST_DIVOP].mb[1]), .p(e1));
  ptc_mul64 u_mul_f0 (.clk, .en(pipe_en), .a(st_r[ST_PS].ma[0]), .b(st_r[ST_PS].mb[0]),
                      .p(f0));
  ptc_mul64 u_mul_f1 (.clk, .en(pipe_en), .a(st_r[ST_PS].ma[1]), .b(st_r[ST_PS].mb[1]),
                      .p(f1));
  ptc_mul64 u_mul_g  (.clk, .en(pipe_en), .a(st_r[ST_SQ].ma[0]), .b(st_r[ST_SQ].mb[0]),
                      .p(g0));

  always_comb begin
    logic [63:0] s_v;
    logic [63:0] x_v;
    logic [63:0] b_v;
    logic [63:0] t_v;
    logic [31:0] rem_v;
    logic [31:0] tr_v;
    logic [63:0] num_v;

    st_nxt[0] = '0;
    for (int k = 1; k < NST; k++) begin
      st_nxt[k] = st_r[k-1];
    end

    // Temperature difference terms
    st_nxt[0].vld   = in_tvalid;
    st_nxt[0].at    = in_tdata[19:0];
    st_nxt[0].ap    = in_tdata[39:20];
    st_nxt[0].ma[0] = {47'd0, in_tdata[19:3]} - {47'd0, t1_r, 1'b0};
    st_nxt[0].mb[0] = ptc_pkg::ptc_sext16(t2_r);
    st_nxt[0].ma[1] = {48'd0, in_tdata[19:4]} - {48'd0, t1_r};
    st_nxt[0].mb[1] = {48'd0, in_tdata[19:4]} - {48'd0, t1_r};

    st_nxt[ST_T2].w0    = ptc_pkg::ptc_asr(p1a, 11);
    st_nxt[ST_T2].ma[0] = ptc_pkg::ptc_asr(p1b, 12);
    st_nxt[ST_T2].mb[0] = ptc_pkg::ptc_sext16(t3_r);

    // Fine temperature saturates to the signed 32-bit range.
    s_v = st_r[ST_TF-1].w0 + ptc_pkg::ptc_asr(p2, 14);
    if (s_v[63:31] != {33{s_v[63]}}) begin
      st_nxt[ST_TF].tf = s_v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      st_nxt[ST_TF].tf = s_v[31:0];
    end

    x_v = {{32{st_r[ST_X-1].tf[31]}}, st_r[ST_X-1].tf} - ptc_pkg::FINE_OFFSET;
    st_nxt[ST_X].ma[0] = x_v;
    st_nxt[ST_X].mb[0] = x_v;
    st_nxt[ST_X].ma[1] = x_v;
    st_nxt[ST_X].mb[1] = ptc_pkg::ptc_sext16(p25_r[63:48]);
    st_nxt[ST_X].ma[2] = x_v;
    st_nxt[ST_X].mb[2] = ptc_pkg::ptc_sext16(p25_r[15:0]);
    st_nxt[ST_X].ma[3] = {{32{st_r[ST_X-1].tf[31]}}, st_r[ST_X-1].tf};
    st_nxt[ST_X].mb[3] = 64'd5;

    t_v = ptc_pkg::ptc_asr(q3 + 64'd128, 8);
    st_nxt[ST_TC].tc    = t_v[31:0];
    st_nxt[ST_TC].w0    = q1;
    st_nxt[ST_TC].w1    = q2;
    st_nxt[ST_TC].ma[0] = q0;
    st_nxt[ST_TC].mb[0] = ptc_pkg::ptc_sext16(p69_r[15:0]);
    st_nxt[ST_TC].ma[1] = q0;
    st_nxt[ST_TC].mb[1] = ptc_pkg::ptc_sext16(p25_r[31:16]);

    st_nxt[ST_SUM].w0 = r0 + (st_r[ST_SUM-1].w0 << 17)
                      + (ptc_pkg::ptc_sext16(p25_r[47:32]) << 35);
    st_nxt[ST_SUM].w1 = ptc_pkg::ptc_asr(r1, 8) + (st_r[ST_SUM-1].w1 << 12);
    st_nxt[ST_SUM].w2 = ptc_pkg::PRESS_BASE - {44'd0, st_r[ST_SUM-1].ap};

    st_nxt[ST_DIVOP].ma[0] = ptc_pkg::P1_BIAS + st_r[ST_DIVOP-1].w1;
    st_nxt[ST_DIVOP].mb[0] = {48'd0, p1_r};
    st_nxt[ST_DIVOP].ma[1] = (st_r[ST_DIVOP-1].w2 << 31) - st_r[ST_DIVOP-1].w0;
    st_nxt[ST_DIVOP].mb[1] = ptc_pkg::PRESS_SCALE;

    b_v = ptc_pkg::ptc_asr(e0, 33);
    st_nxt[ST_QUOT].dz = (b_v == 64'd0);
    st_nxt[ST_QUOT].w0 = e1;
    st_nxt[ST_QUOT].w1 = b_v;

    // Divide magnitudes; the divisor lies within plus or minus 2^30.
    st_nxt[ST_DIV].num  = st_r[ST_DIV-1].w0[63] ? (64'd0 - st_r[ST_DIV-1].w0)
                                                : st_r[ST_DIV-1].w0;
    st_nxt[ST_DIV].den  = st_r[ST_DIV-1].w1[63] ? (32'd0 - st_r[ST_DIV-1].w1[31:0])
                                                : st_r[ST_DIV-1].w1[31:0];
    st_nxt[ST_DIV].qneg = st_r[ST_DIV-1].w0[63] ^ st_r[ST_DIV-1].w1[63];
    st_nxt[ST_DIV].rem  = '0;

    // Restoring division, two quotient bits a stage shifted into num.
    for (int k = ST_DIV + 1; k <= ST_DIV + DIV_STAGES; k++) begin
      rem_v = st_r[k-1].rem;
      num_v = st_r[k-1].num;
      for (int j = 0; j < 2; j++) begin
        tr_v  = {rem_v[30:0], num_v[63]};
        num_v = {num_v[62:0], 1'b0};
        if (tr_v >= st_r[k-1].den) begin
          rem_v    = tr_v - st_r[k-1].den;
          num_v[0] = 1'b1;
        end else begin
          rem_v = tr_v;
        end
      end
      st_nxt[k].rem = rem_v;
      st_nxt[k].num = num_v;
    end

    st_nxt[ST_NEG].w0 = st_r[ST_NEG-1].qneg ? (64'd0 - st_r[ST_NEG-1].num)
                                            : st_r[ST_NEG-1].num;

    st_nxt[ST_PS].w1    = ptc_pkg::ptc_asr(st_r[ST_PS-1].w0, 13);
    st_nxt[ST_PS].ma[0] = ptc_pkg::ptc_sext16(p69_r[63:48]);
    st_nxt[ST_PS].mb[0] = ptc_pkg::ptc_asr(st_r[ST_PS-1].w0, 13);
    st_nxt[ST_PS].ma[1] = ptc_pkg::ptc_sext16(p69_r[47:32]);
    st_nxt[ST_PS].mb[1] = st_r[ST_PS-1].w0;

    st_nxt[ST_SQ].ma[0] = f0;
    st_nxt[ST_SQ].mb[0] = st_r[ST_SQ-1].w1;
    st_nxt[ST_SQ].w2    = ptc_pkg::ptc_asr(f1, 19);

    st_nxt[ST_ADD1].w0 = st_r[ST_ADD1-1].w0 + ptc_pkg::ptc_asr(g0, 25) + st_r[ST_ADD1-1].w2;
    st_nxt[ST_ADD2].w0 = ptc_pkg::ptc_asr(st_r[ST_ADD2-1].w0, 8)
                       + (ptc_pkg::ptc_sext16(p69_r[31:16]) << 4);

    if (st_r[ST_CLAMP-1].dz || st_r[ST_CLAMP-1].w0[63]) begin
      st_nxt[ST_CLAMP].pout = '0;
    end else if (st_r[ST_CLAMP-1].w0[63:32] != 32'd0) begin
      st_nxt[ST_CLAMP].pout = 32'hFFFF_FFFF;
    end else begin
      st_nxt[ST_CLAMP].pout = st_r[ST_CLAMP-1].w0[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        st_r[k].vld <= 1'b0;
      end
    end else if (pipe_en) begin
      for (int k = 0; k < NST; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign last_data = {st_r[NST-1].pout, st_r[NST-1].tc, st_r[NST-1].tf};

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      skid_full_r  <= 1'b0;
    end else if (!out_tvalid_r || out_tready) begin
      out_tvalid_r <= skid_full_r || (pipe_en && st_r[NST-1].vld);
      skid_full_r  <= 1'b0;
    end else if (pipe_en && st_r[NST-1].vld) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_tvalid_r || out_tready) begin
      out_tdata_r <= skid_full_r ? skid_data_r : last_data;
      out_tuser_r <= skid_full_r ? skid_user_r : st_r[NST-1].dz;
    end else if (pipe_en) begin
      skid_data_r <= last_data;
      skid_user_r <= st_r[NST-1].dz;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `PTC_ASSERT_NOW(a_skid_needs_out, skid_full_r, out_tvalid_r, "skid full without output word")
  `PTC_ASSERT_NOW(a_skid_cause, $rose(skid_full_r), $past(out_tvalid_r && !out_tready),
                  "skid filled while output was free")
  `PTC_ASSERT_NOW(a_dz_zero, out_tvalid_r && out_tuser_r, out_tdata_r[95:64] == 32'd0,
                  "zero divisor word carries nonzero pressure")
  `PTC_ASSERT_NEXT(a_frozen, skid_full_r, st_r[NST-1] == $past(st_r[NST-1]),
                   "pipeline moved while output buffer full")

endmodule
`default_nettype wire
